// ===== design/spcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI path command receiver package
// Shared codes, constants and the controller command bundle.
// ----------------------------------------------------------------------------
package spcr_pkg;

  // Transaction kinds on the input channel.
  localparam logic [2:0] KIND_SPI     = 3'd0;
  localparam logic [2:0] KIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_POS_WR  = 3'd2;
  localparam logic [2:0] KIND_FORCE   = 3'd3;
  localparam logic [2:0] KIND_PATH_RD = 3'd4;

  // Protocol bytes and reset values.
  localparam logic [7:0] POLL_BYTE   = 8'd254;
  localparam logic [7:0] AWAIT_BYTE  = 8'd255;
  localparam logic [7:0] ROLE_AWAIT  = 8'd2;
  localparam logic [7:0] ROLE_LEAD   = 8'd1;
  localparam logic [7:0] ROLE_FOLLOW = 8'd0;
  localparam logic [7:0] POSE_RESET  = 8'd10;
  localparam int         POS_COUNT   = 7;
  localparam logic [2:0] POS_LAST    = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the accepted input transaction
    logic exec;     // apply the transaction to the state
    logic capture;  // latch the path table read data
  } ctl_cmd_t;

endpackage
`default_nettype wire

// ===== design/spcr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== design/spcr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Receiver controller
// Sequences each transaction through execute, table read and result phases.
// ----------------------------------------------------------------------------
module spcr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output spcr_pkg::ctl_cmd_t     cmd
);
  import spcr_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_RDWAIT = 2'd2;
  localparam logic [1:0] ST_RESP   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = ST_RDWAIT;
      ST_RDWAIT: state_nxt = ST_RESP;
      ST_RESP:   if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Handshake and datapath commands.
  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = (state_r == ST_RESP);
  assign cmd.load    = in_ready && in_valid;
  assign cmd.exec    = (state_r == ST_EXEC);
  assign cmd.capture = (state_r == ST_RDWAIT);

`ifndef NO_ASSERTIONS
  // The two channels are never open at the same time.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output open together");

  // Execution is always followed by the read capture phase.
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> cmd.capture) else $error("capture did not follow execute");

  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result withdrawn");
`endif

endmodule
`default_nettype wire

// ===== design/spcr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Receiver datapath
// Protocol state, position store, path table and result registers.
// ----------------------------------------------------------------------------
module spcr_dp #(
  parameter int PATH_DEPTH = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  spcr_pkg::ctl_cmd_t      cmd,
  input  wire logic [2:0]         in_kind,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic [6:0]         in_entry_index,
  output logic                    reply_valid,
  output logic      [7:0]         reply_byte,
  output logic                    path_ready,
  output logic      [7:0]         agent_count,
  output logic      [7:0]         leader_code,
  output logic      [7:0]         stop_index,
  output logic      [7:0]         follower_vx,
  output logic      [7:0]         follower_vy,
  output logic      [7:0]         path_x,
  output logic      [7:0]         path_y
);
  import spcr_pkg::*;

  localparam int         AW      = $clog2(PATH_DEPTH);
  localparam logic [8:0] DEPTH_W = 9'(PATH_DEPTH);

  // Captured transaction.
  logic [2:0] kind_r;
  logic [7:0] byte_r;
  logic [6:0] idx_r;

  // Protocol state.
  logic [7:0] pos_r [POS_COUNT];
  logic [7:0] pos_nxt [POS_COUNT];
  logic [2:0] rptr_r, rptr_nxt;
  logic [7:0] agents_r, agents_nxt;
  logic [7:0] role_r, role_nxt;
  logic       ready_r, ready_nxt;
  logic       half_r, half_nxt;
  logic [7:0] pc_r, pc_nxt;
  logic [7:0] lastwp_r, lastwp_nxt;
  logic [7:0] pose_x_r, pose_x_nxt;
  logic [7:0] pose_y_r, pose_y_nxt;
  logic       pose_ptr_r, pose_ptr_nxt;
  logic       force_r, force_nxt;
  logic [7:0] first_r, first_nxt;
  logic [PATH_DEPTH-1:0] xvld_r, xvld_nxt;
  logic [PATH_DEPTH-1:0] yvld_r, yvld_nxt;

  // Result registers.
  logic       reply_valid_r, reply_valid_nxt;
  logic [7:0] reply_byte_r, reply_byte_nxt;
  logic [7:0] path_x_r, path_y_r;
  logic       rd_ok_r, rd_vx_r, rd_vy_r;

  // Table access.
  logic          x_we, y_we;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    x_q, y_q;
  logic [7:0]    idx_ext;
  logic          pc_in_rng, idx_in_rng;
  logic          agents_gt1, path_mode, follow_mode;
  logic [2:0]    rp;

  assign idx_ext     = {1'b0, idx_r};
  assign wr_addr     = pc_r[AW-1:0];
  assign rd_addr     = idx_ext[AW-1:0];
  assign pc_in_rng   = ({1'b0, pc_r} < DEPTH_W);
  assign idx_in_rng  = ({2'b00, idx_r} < DEPTH_W);
  assign agents_gt1  = (agents_r > 8'd1);
  assign path_mode   = (agents_r == 8'd1) || (agents_gt1 && role_r == ROLE_LEAD);
  assign follow_mode = agents_gt1 && (role_r == ROLE_FOLLOW);
  assign rp          = (rptr_r < 3'(POS_COUNT)) ? rptr_r : 3'd0;

  // Transaction capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      byte_r <= in_data_byte;
      idx_r  <= in_entry_index;
    end
  end

  // State update for one transaction.
  always_comb begin
    pos_nxt         = pos_r;
    rptr_nxt        = rptr_r;
    agents_nxt      = agents_r;
    role_nxt        = role_r;
    ready_nxt       = ready_r;
    half_nxt        = half_r;
    pc_nxt          = pc_r;
    lastwp_nxt      = lastwp_r;
    pose_x_nxt      = pose_x_r;
    pose_y_nxt      = pose_y_r;
    pose_ptr_nxt    = pose_ptr_r;
    force_nxt       = force_r;
    first_nxt       = first_r;
    xvld_nxt        = xvld_r;
    yvld_nxt        = yvld_r;
    reply_valid_nxt = reply_valid_r;
    reply_byte_nxt  = reply_byte_r;
    x_we            = 1'b0;
    y_we            = 1'b0;
    if (cmd.load) begin
      reply_valid_nxt = 1'b0;
      reply_byte_nxt  = 8'd0;
    end else if (cmd.exec) begin
      unique case (kind_r)
        KIND_SPI: begin
          priority if (byte_r == POLL_BYTE) begin
            // Poll: return the next position byte.
            reply_valid_nxt = 1'b1;
            reply_byte_nxt  = pos_r[rp];
            rptr_nxt        = (rp == POS_LAST) ? 3'd0 : rp + 3'd1;
          end else if (agents_r == AWAIT_BYTE) begin
            agents_nxt = force_r ? 8'd1 : byte_r;
            force_nxt  = 1'b0;
          end else if (role_r == ROLE_AWAIT) begin
            role_nxt     = byte_r;
            pose_ptr_nxt = 1'b0;
          end else if (path_mode) begin
            // Coordinate pairs until a terminator pair.
            if (!ready_r) begin
              if (!half_r) begin
                first_nxt = byte_r;
                half_nxt  = 1'b1;
                if (pc_in_rng) begin
                  x_we              = 1'b1;
                  xvld_nxt[wr_addr] = 1'b1;
                end
              end else begin
                half_nxt = 1'b0;
                pc_nxt   = pc_r + 8'd1;
                if (pc_in_rng) begin
                  y_we              = 1'b1;
                  yvld_nxt[wr_addr] = 1'b1;
                end
                if (first_r == AWAIT_BYTE && byte_r == AWAIT_BYTE) begin
                  if (agents_gt1 && role_r == ROLE_LEAD) begin
                    pos_nxt[5] = 8'd1;
                    pos_nxt[6] = 8'd1;
                  end
                  ready_nxt  = 1'b1;
                  lastwp_nxt = pc_r - 8'd1;
                  pc_nxt     = 8'd0;
                  rptr_nxt   = 3'd0;
                end
              end
            end
          end else if (follow_mode) begin
            // Follower velocity pair.
            if (!pose_ptr_r) begin
              pose_x_nxt   = byte_r;
              pose_ptr_nxt = 1'b1;
            end else begin
              pose_y_nxt   = byte_r;
              ready_nxt    = 1'b1;
              pose_ptr_nxt = 1'b0;
              rptr_nxt     = 3'd0;
            end
          end
        end
        KIND_RELEASE: begin
          xvld_nxt   = '0;
          yvld_nxt   = '0;
          ready_nxt  = 1'b0;
          agents_nxt = AWAIT_BYTE;
          role_nxt   = ROLE_AWAIT;
        end
        KIND_POS_WR: begin
          if (idx_r < 7'(POS_COUNT)) begin
            pos_nxt[idx_r[2:0]] = byte_r;
          end
        end
        KIND_FORCE: begin
          force_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POS_COUNT; i++) begin
        pos_r[i] <= 8'd0;
      end
      rptr_r        <= 3'd0;
      agents_r      <= AWAIT_BYTE;
      role_r        <= ROLE_AWAIT;
      ready_r       <= 1'b0;
      half_r        <= 1'b0;
      pc_r          <= 8'd0;
      lastwp_r      <= 8'd0;
      pose_x_r      <= POSE_RESET;
      pose_y_r      <= POSE_RESET;
      pose_ptr_r    <= 1'b0;
      force_r       <= 1'b0;
      first_r       <= 8'd0;
      xvld_r        <= '0;
      yvld_r        <= '0;
      reply_valid_r <= 1'b0;
      reply_byte_r  <= 8'd0;
    end else begin
      pos_r         <= pos_nxt;
      rptr_r        <= rptr_nxt;
      agents_r      <= agents_nxt;
      role_r        <= role_nxt;
      ready_r       <= ready_nxt;
      half_r        <= half_nxt;
      pc_r          <= pc_nxt;
      lastwp_r      <= lastwp_nxt;
      pose_x_r      <= pose_x_nxt;
      pose_y_r      <= pose_y_nxt;
      pose_ptr_r    <= pose_ptr_nxt;
      force_r       <= force_nxt;
      first_r       <= first_nxt;
      xvld_r        <= xvld_nxt;
      yvld_r        <= yvld_nxt;
      reply_valid_r <= reply_valid_nxt;
      reply_byte_r  <= reply_byte_nxt;
    end
  end

  // Path table, one memory per coordinate.
  spcr_ram #(.WIDTH(8), .DEPTH(PATH_DEPTH)) u_ram_x (
    .clk     (clk),
    .wr_en   (x_we),
    .wr_addr (wr_addr),
    .wr_data (byte_r),
    .rd_addr (rd_addr),
    .rd_data (x_q)
  );

  spcr_ram #(.WIDTH(8), .DEPTH(PATH_DEPTH)) u_ram_y (
    .clk     (clk),
    .wr_en   (y_we),
    .wr_addr (wr_addr),
    .wr_data (byte_r),
    .rd_addr (rd_addr),
    .rd_data (y_q)
  );

  // Table read: qualify with range and entry valid bits, then capture.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_ok_r <= (kind_r == KIND_PATH_RD) && idx_in_rng;
      rd_vx_r <= xvld_r[rd_addr];
      rd_vy_r <= yvld_r[rd_addr];
    end
    if (cmd.capture) begin
      path_x_r <= (rd_ok_r && rd_vx_r) ? x_q : 8'd0;
      path_y_r <= (rd_ok_r && rd_vy_r) ? y_q : 8'd0;
    end
  end

  assign reply_valid = reply_valid_r;
  assign reply_byte  = reply_byte_r;
  assign path_ready  = ready_r;
  assign agent_count = agents_r;
  assign leader_code = role_r;
  assign stop_index  = lastwp_r;
  assign follower_vx = pose_x_r;
  assign follower_vy = pose_y_r;
  assign path_x      = path_x_r;
  assign path_y      = path_y_r;

`ifndef NO_ASSERTIONS
  // The reply pointer only ever holds a position byte index.
  a_rptr: assert property (@(posedge clk) disable iff (!rst_n)
    rptr_r != 3'd7) else $error("reply pointer out of range");

  // A release empties the table and returns to the awaiting state.
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && kind_r == KIND_RELEASE) |=>
      (xvld_r == '0 && yvld_r == '0 && !ready_r && agents_r == AWAIT_BYTE))
    else $error("release did not clear state");

  // A reply is loaded only by a poll byte.
  a_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !(kind_r == KIND_SPI && byte_r == POLL_BYTE)) |=> !reply_valid_r)
    else $error("reply loaded by a non-poll transaction");
`endif

endmodule
`default_nettype wire

// ===== design/spi_path_command_receiver_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI path command receiver core
// Top level: controller and datapath of the SPI path command receiver.
// ----------------------------------------------------------------------------
// A transaction is accepted in an idle cycle, executes in the next cycle and
// then waits in the read-wait state for the registered read port of the path
// table before its result is offered. The next transaction is accepted in the
// cycle after the result is taken, so the block takes no new transaction until
// the result of the last one has been taken. This sequence is set by the
// controller around the registered read port of the path table memory. Release
// clears the path table through per-entry valid bits; no clearing pass runs
// after reset.
// ----------------------------------------------------------------------------
module spi_path_command_receiver_core #(
  parameter int PATH_DEPTH = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_kind,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [6:0] in_entry_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_reply_valid,
  output logic      [7:0] out_reply_byte,
  output logic            out_path_ready,
  output logic      [7:0] out_agent_count,
  output logic      [7:0] out_leader_code,
  output logic      [7:0] out_stop_index,
  output logic      [7:0] out_follower_vx,
  output logic      [7:0] out_follower_vy,
  output logic      [7:0] out_path_x,
  output logic      [7:0] out_path_y
);
  import spcr_pkg::*;

  ctl_cmd_t cmd;

  // Transaction sequencer.
  spcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Protocol state and path table.
  spcr_dp #(.PATH_DEPTH(PATH_DEPTH)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_kind        (in_kind),
    .in_data_byte   (in_data_byte),
    .in_entry_index (in_entry_index),
    .reply_valid    (out_reply_valid),
    .reply_byte     (out_reply_byte),
    .path_ready     (out_path_ready),
    .agent_count    (out_agent_count),
    .leader_code    (out_leader_code),
    .stop_index     (out_stop_index),
    .follower_vx    (out_follower_vx),
    .follower_vy    (out_follower_vy),
    .path_x         (out_path_x),
    .path_y         (out_path_y)
  );

endmodule
`default_nettype wire

// ===== sim/tb_spi_path_command_receiver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the SPI path command receiver core
// Drives SPI bytes and host requests through the valid/ready input channel,
// predicts every result with a behavioral copy of the receiver state, and
// checks each result field by field under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_spi_path_command_receiver_core;
  import spcr_pkg::*;

  localparam int PATH_DEPTH = 128;
  localparam int AW         = $clog2(PATH_DEPTH);

  // One result transaction, field by field.
  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       path_ready;
    logic [7:0] agent_count;
    logic [7:0] leader_code;
    logic [7:0] stop_index;
    logic [7:0] follower_vx;
    logic [7:0] follower_vy;
    logic [7:0] path_x;
    logic [7:0] path_y;
  } status_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [2:0] in_kind = '0;
  logic [7:0] in_data_byte = '0;
  logic [6:0] in_entry_index = '0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       out_reply_valid;
  logic [7:0] out_reply_byte;
  logic       out_path_ready;
  logic [7:0] out_agent_count;
  logic [7:0] out_leader_code;
  logic [7:0] out_stop_index;
  logic [7:0] out_follower_vx;
  logic [7:0] out_follower_vy;
  logic [7:0] out_path_x;
  logic [7:0] out_path_y;

  spi_path_command_receiver_core #(.PATH_DEPTH(PATH_DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_data_byte   (in_data_byte),
    .in_entry_index (in_entry_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reply_valid(out_reply_valid),
    .out_reply_byte (out_reply_byte),
    .out_path_ready (out_path_ready),
    .out_agent_count(out_agent_count),
    .out_leader_code(out_leader_code),
    .out_stop_index (out_stop_index),
    .out_follower_vx(out_follower_vx),
    .out_follower_vy(out_follower_vy),
    .out_path_x     (out_path_x),
    .out_path_y     (out_path_y)
  );

  // Clock: 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted receiver state.
  logic [7:0] way_x [PATH_DEPTH];
  logic [7:0] way_y [PATH_DEPTH];
  logic [7:0] pose_bytes [POS_COUNT];
  logic [2:0] poll_ptr = '0;
  logic [7:0] agents_now = AWAIT_BYTE;
  logic [7:0] role_now = ROLE_AWAIT;
  logic       ready_now = 1'b0;
  logic       mid_pair = 1'b0;
  logic [7:0] pairs_seen = '0;
  logic [7:0] stop_now = '0;
  logic [7:0] vel_x = POSE_RESET;
  logic [7:0] vel_y = POSE_RESET;
  logic       vel_second = 1'b0;
  logic       force_pending = 1'b0;
  logic [7:0] pair_first = '0;

  status_t expected_status [$];

  // Traffic shaping and bookkeeping.
  bit          gappy = 1'b1;
  bit          stall_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned sent_items = 0;
  int unsigned results_checked = 0;
  int unsigned error_count = 0;
  int unsigned paths_done = 0;
  int unsigned poses_done = 0;
  int unsigned polls = 0;

  // Applies one transaction to the predicted state and returns its result.
  function automatic status_t predict_status(logic [2:0] kind, logic [7:0] value,
                                             logic [6:0] index);
    status_t    s;
    logic [2:0] p;
    s = '0;
    case (kind)
      KIND_SPI: begin
        if (value == POLL_BYTE) begin
          p = (poll_ptr < POS_COUNT) ? poll_ptr : 3'd0;
          s.reply_valid = 1'b1;
          s.reply_byte  = pose_bytes[p];
          poll_ptr = (p == POS_LAST) ? 3'd0 : p + 3'd1;
          polls++;
        end else if (agents_now == AWAIT_BYTE) begin
          agents_now = force_pending ? 8'd1 : value;
          force_pending = 1'b0;
        end else if (role_now == ROLE_AWAIT) begin
          role_now = value;
          vel_second = 1'b0;
        end else if (agents_now == 8'd1 || (agents_now > 8'd1 && role_now == ROLE_LEAD)) begin
          // Path bytes are dropped once the path is complete.
          if (!ready_now) begin
            if (!mid_pair) begin
              pair_first = value;
              if (pairs_seen < PATH_DEPTH) way_x[pairs_seen[AW-1:0]] = value;
              mid_pair = 1'b1;
            end else begin
              if (pairs_seen < PATH_DEPTH) way_y[pairs_seen[AW-1:0]] = value;
              mid_pair = 1'b0;
              pairs_seen = pairs_seen + 8'd1;
              if (pair_first == AWAIT_BYTE && value == AWAIT_BYTE) begin
                if (agents_now > 8'd1 && role_now == ROLE_LEAD) begin
                  pose_bytes[POS_LAST - 3'd1] = 8'd1;
                  pose_bytes[POS_LAST] = 8'd1;
                end
                ready_now  = 1'b1;
                stop_now   = pairs_seen - 8'd2;
                pairs_seen = '0;
                poll_ptr   = '0;
                paths_done++;
              end
            end
          end
        end else if (agents_now > 8'd1 && role_now == ROLE_FOLLOW) begin
          // Follower velocity pairs are taken even with the pose ready.
          if (!vel_second) begin
            vel_x = value;
            vel_second = 1'b1;
          end else begin
            vel_y = value;
            ready_now = 1'b1;
            vel_second = 1'b0;
            poll_ptr = '0;
            poses_done++;
          end
        end
      end
      KIND_RELEASE: begin
        foreach (way_x[i]) begin
          way_x[i] = '0;
          way_y[i] = '0;
        end
        ready_now  = 1'b0;
        agents_now = AWAIT_BYTE;
        role_now   = ROLE_AWAIT;
      end
      KIND_POS_WR: begin
        if (index < POS_COUNT) pose_bytes[index[2:0]] = value;
      end
      KIND_FORCE: begin
        force_pending = 1'b1;
      end
      KIND_PATH_RD: begin
        if (index < PATH_DEPTH) begin
          s.path_x = way_x[index[AW-1:0]];
          s.path_y = way_y[index[AW-1:0]];
        end
      end
      default: begin
      end
    endcase
    s.path_ready  = ready_now;
    s.agent_count = agents_now;
    s.leader_code = role_now;
    s.stop_index  = stop_now;
    s.follower_vx = vel_x;
    s.follower_vy = vel_y;
    return s;
  endfunction

  // Gap before a transaction: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gappy || r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one transaction and records its expected result on acceptance.
  task automatic send_item(input logic [2:0] kind, input logic [7:0] value,
                           input logic [6:0] index);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_data_byte   <= value;
    in_entry_index <= index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_status.push_back(predict_status(kind, value, index));
    sent_items++;
  endtask

  // A random host request or poll, interleaved with SPI traffic.
  task automatic send_noise();
    case ($urandom_range(0, 5))
      0, 1: send_item(KIND_SPI, POLL_BYTE, 7'($urandom));
      2: send_item(KIND_POS_WR, 8'($urandom),
                   ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 6)));
      3: send_item(KIND_PATH_RD, 8'($urandom), 7'($urandom));
      4: send_item(3'($urandom_range(5, 7)), 8'($urandom), 7'($urandom));
      default: send_item(3'($urandom), 8'($urandom), 7'($urandom));
    endcase
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Checks one accepted result against the oldest expectation.
  task automatic check_status();
    status_t want;
    if (expected_status.size() == 0) begin
      $error("result transaction with no request outstanding");
      error_count++;
    end else begin
      want = expected_status.pop_front();
      compare_field("reply_valid", 32'(want.reply_valid), 32'(out_reply_valid));
      compare_field("reply_byte", 32'(want.reply_byte), 32'(out_reply_byte));
      compare_field("path_ready", 32'(want.path_ready), 32'(out_path_ready));
      compare_field("agent_count", 32'(want.agent_count), 32'(out_agent_count));
      compare_field("leader_code", 32'(want.leader_code), 32'(out_leader_code));
      compare_field("stop_index", 32'(want.stop_index), 32'(out_stop_index));
      compare_field("follower_vx", 32'(want.follower_vx), 32'(out_follower_vx));
      compare_field("follower_vy", 32'(want.follower_vy), 32'(out_follower_vy));
      compare_field("path_x", 32'(want.path_x), 32'(out_path_x));
      compare_field("path_y", 32'(want.path_y), 32'(out_path_y));
      results_checked++;
    end
  endtask

  // Result side: check on each handshake and stall the receiver at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_status();
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Position writes, including indexes past the store, then polls that wrap.
  task automatic test_position_poll();
    send_item(KIND_POS_WR, 8'd255, 7'd0);
    send_item(KIND_POS_WR, 8'd128, 7'(POS_LAST));
    send_item(KIND_POS_WR, 8'd77, 7'd7);
    send_item(KIND_POS_WR, 8'd1, 7'd127);
    repeat (8) send_item(KIND_SPI, POLL_BYTE, 7'd0);
  endtask

  // Forced single mode; a 255,255 that straddles two pairs does not end the path.
  task automatic test_single_path();
    send_item(KIND_FORCE, 8'd0, 7'd0);
    send_item(KIND_SPI, 8'd9, 7'd0);
    send_item(KIND_SPI, ROLE_FOLLOW, 7'd0);
    send_item(KIND_SPI, 8'd3, 7'd0);
    send_item(KIND_SPI, AWAIT_BYTE, 7'd0);
    send_item(KIND_SPI, AWAIT_BYTE, 7'd0);
    send_item(KIND_SPI, 8'd4, 7'd0);
    send_item(KIND_SPI, AWAIT_BYTE, 7'd0);
    send_item(KIND_SPI, AWAIT_BYTE, 7'd0);
    send_item(KIND_SPI, 8'd5, 7'd0);
    send_item(KIND_PATH_RD, 8'd0, 7'd1);
    send_item(KIND_RELEASE, 8'd0, 7'd0);
  endtask

  // Leader path of only a terminator, a follower pose, and an unsupported mode.
  task automatic test_leader_follower();
    send_item(KIND_SPI, 8'd2, 7'd0);
    send_item(KIND_SPI, ROLE_LEAD, 7'd0);
    send_item(KIND_SPI, AWAIT_BYTE, 7'd0);
    send_item(KIND_SPI, AWAIT_BYTE, 7'd0);
    send_item(KIND_SPI, POLL_BYTE, 7'd0);
    send_item(KIND_RELEASE, 8'd0, 7'd0);
    send_item(KIND_SPI, 8'd3, 7'd0);
    send_item(KIND_SPI, ROLE_FOLLOW, 7'd0);
    send_item(KIND_SPI, 8'd0, 7'd0);
    send_item(KIND_SPI, 8'd255, 7'd0);
    send_item(KIND_RELEASE, 8'd0, 7'd0);
    send_item(KIND_SPI, 8'd0, 7'd0);
    send_item(KIND_SPI, 8'd9, 7'd0);
    send_item(KIND_SPI, 8'd8, 7'd0);
    send_item(3'd7, 8'd255, 7'd127);
  endtask

  // A path longer than the table: the pair count wraps and late pairs are dropped.
  task automatic test_table_overflow();
    logic [7:0] x;
    logic [7:0] y;
    send_item(KIND_RELEASE, 8'($urandom), 7'($urandom));
    send_item(KIND_SPI, 8'd1, 7'($urandom));
    send_item(KIND_SPI, 8'($urandom_range(0, 253)), 7'($urandom));
    repeat (300) begin
      x = 8'($urandom_range(0, 253));
      y = 8'($urandom_range(0, 255));
      if (y == POLL_BYTE) y = 8'd0;
      send_item(KIND_SPI, x, 7'($urandom));
      send_item(KIND_SPI, y, 7'($urandom));
    end
    send_item(KIND_SPI, AWAIT_BYTE, 7'($urandom));
    send_item(KIND_SPI, AWAIT_BYTE, 7'($urandom));
    repeat (20) send_item(KIND_PATH_RD, 8'($urandom), 7'($urandom));
    repeat (3) send_item(KIND_SPI, POLL_BYTE, 7'($urandom));
  endtask

  // Random sessions: setup bytes, then a path or velocity pairs with noise mixed in.
  task automatic test_random_sessions(input int unsigned target);
    int unsigned stop_at;
    int unsigned pairs;
    logic [7:0]  x;
    logic [7:0]  y;
    stop_at = sent_items + target;
    while (sent_items < stop_at) begin
      gappy    = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) != 0) send_item(KIND_RELEASE, 8'($urandom), 7'($urandom));
      if ($urandom_range(0, 4) == 0) send_item(KIND_FORCE, 8'($urandom), 7'($urandom));
      case ($urandom_range(0, 9))
        0: send_item(KIND_SPI, 8'd0, 7'($urandom));
        1, 2, 3: send_item(KIND_SPI, 8'd1, 7'($urandom));
        4: send_item(KIND_SPI, 8'($urandom_range(0, 255)), 7'($urandom));
        default: send_item(KIND_SPI, 8'($urandom_range(2, 6)), 7'($urandom));
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2: send_item(KIND_SPI, 8'($urandom_range(0, 255)), 7'($urandom));
        3, 4, 5, 6, 7, 8, 9, 10: send_item(KIND_SPI, ROLE_FOLLOW, 7'($urandom));
        default: send_item(KIND_SPI, ROLE_LEAD, 7'($urandom));
      endcase
      pairs = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      repeat (pairs) begin
        x = 8'($urandom_range(0, 253));
        y = 8'($urandom_range(0, 253));
        if ($urandom_range(0, 7) == 0) x = AWAIT_BYTE;
        if ($urandom_range(0, 7) == 0) send_noise();
        send_item(KIND_SPI, x, 7'($urandom));
        if ($urandom_range(0, 7) == 0) send_noise();
        send_item(KIND_SPI, y, 7'($urandom));
      end
      case ($urandom_range(0, 9))
        0: send_item(KIND_SPI, AWAIT_BYTE, 7'($urandom));
        1: begin
        end
        default: begin
          send_item(KIND_SPI, AWAIT_BYTE, 7'($urandom));
          send_item(KIND_SPI, AWAIT_BYTE, 7'($urandom));
        end
      endcase
      repeat ($urandom_range(0, 4)) send_noise();
    end
  endtask

  // Unstructured transactions of every kind and value.
  task automatic test_random_noise(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 1) == 0) send_item(KIND_SPI, 8'($urandom), 7'($urandom));
      else send_item(3'($urandom), 8'($urandom), 7'($urandom));
    end
  endtask

  initial begin
    foreach (way_x[i]) begin
      way_x[i] = '0;
      way_y[i] = '0;
    end
    foreach (pose_bytes[i]) pose_bytes[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_position_poll();
    test_single_path();
    test_leader_follower();
    test_table_overflow();
    test_random_sessions(450);
    gappy    = 1'b1;
    stall_on = 1'b1;
    test_random_noise(150);

    // Drain the remaining results, then allow a few idle cycles.
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("Sent %0d transactions and checked %0d results.", sent_items, results_checked);
    $display("Covered %0d completed paths, %0d follower poses and %0d polls.",
             paths_done, poses_done, polls);
    if (error_count == 0) begin
      $display("spi_path_command_receiver_core verification clean");
    end else begin
      $display("spi_path_command_receiver_core verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("spi_path_command_receiver_core verification failed");
    $finish;
  end

endmodule
